/* rtl/csa_pkg.sv */
`timescale 1ns / 1ps

package csa_pkg;

  // Image store geometry.
  localparam int IMAGE_DEPTH = 65536;
  localparam int ADDR_W = $clog2(IMAGE_DEPTH);
  localparam int COUNT_W = ADDR_W + 1;

  // Data word: Q24.16 fixed point.
  localparam int WORD_W = 40;

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 13;

  // Widths of the address arithmetic stages.
  localparam int ROW_W = 18;
  localparam int POS_W = 32;
  localparam int CHN_W = 44;
  localparam int ADR_W = 54;

  // Counter widths.
  localparam int FILT_CNT_W = 4;
  localparam int CHAN_CNT_W = 10;
  localparam int BATCH_CNT_W = 8;
  localparam int OUT_CNT_W = 12;
  localparam int WRAP_W = 13;

  typedef logic signed [WORD_W-1:0] word_t;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ACCUM = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BATCH_SIZE    = 3'd0,
    REG_CHANNELS      = 3'd1,
    REG_PADDED_HEIGHT = 3'd2,
    REG_OUT_ROWS      = 3'd3,
    REG_OUT_COLS      = 3'd4,
    REG_FILTER_ROWS   = 3'd5,
    REG_FILTER_COLS   = 3'd6,
    REG_STEP          = 3'd7
  } reg_index_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic take_value;
    logic calc_row;
    logic calc_pos;
    logic calc_chn;
    logic calc_adr;
    logic acc_read;
    logic acc_write;
    logic rd_issue;
    logic out_load;
  } csa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_avail;
    logic out_free;
  } csa_status_t;

endpackage

/* rtl/col2im_scatter_accumulate.sv */
`timescale 1ns / 1ps

// Col2im scatter-accumulate for convolution backward passes. Load words fill a
// 65536-word Q24.16 image store in order; column words, filter column fastest,
// are then added (wrapping) into the image address formed from the batch,
// channel, filter offset and output position counters, and dropped when that
// address lies beyond the loaded words; readout words return the store in
// order with last set on the final loaded word, after which all pointers and
// counters return to zero. A load, a readout with nothing left and an unknown
// kind finish in the cycle that accepts them. An accumulate runs the row,
// position, channel and address stages of address arithmetic, then a read and
// a write of the image store. A readout fetches a word, then moves it to the
// output register when free and waits otherwise; that register lets loads and
// accumulates go on while a word waits to be taken. Configure only while idle.
module col2im_scatter_accumulate import csa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic signed [WORD_W-1:0] value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [WORD_W-1:0] pixel,
  output logic                   last,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  csa_cmd_t    cmd;
  csa_status_t status;

  // Sequencer.
  csa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .status   (status),
    .cmd      (cmd)
  );

  // Store, counters and address arithmetic.
  csa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel     (pixel),
    .last      (last)
  );

endmodule

/* rtl/csa_ctrl.sv */
`timescale 1ns / 1ps

module csa_ctrl import csa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  csa_status_t status,
  output csa_cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ROW    = 8'b0000_0010,
    ST_POS    = 8'b0000_0100,
    ST_CHN    = 8'b0000_1000,
    ST_ADR    = 8'b0001_0000,
    ST_ACC_RD = 8'b0010_0000,
    ST_ACC_WR = 8'b0100_0000,
    ST_RD_OUT = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // New words are taken only between operations.
  assign in_ready = (state == ST_IDLE);
  assign accept = in_valid && in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_t'(kind))
            KIND_LOAD: begin
              cmd.load = 1'b1;
            end
            KIND_ACCUM: begin
              cmd.take_value = 1'b1;
              state_next = ST_ROW;
            end
            KIND_READ: begin
              if (status.read_avail) begin
                cmd.rd_issue = 1'b1;
                state_next = ST_RD_OUT;
              end
            end
            KIND_NONE: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_ROW: begin
        cmd.calc_row = 1'b1;
        state_next = ST_POS;
      end
      ST_POS: begin
        cmd.calc_pos = 1'b1;
        state_next = ST_CHN;
      end
      ST_CHN: begin
        cmd.calc_chn = 1'b1;
        state_next = ST_ADR;
      end
      ST_ADR: begin
        cmd.calc_adr = 1'b1;
        state_next = ST_ACC_RD;
      end
      ST_ACC_RD: begin
        cmd.acc_read = 1'b1;
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.acc_write = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_OUT: begin
        // Hold the fetched word until the output register can take it.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/csa_datapath.sv */
`timescale 1ns / 1ps

module csa_datapath import csa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  csa_cmd_t               cmd,
  output csa_status_t            status,
  input  logic [WORD_W-1:0]      value,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output word_t                  pixel,
  output logic                   last
);

  // Configuration registers.
  logic [8:0]  batch_size;
  logic [10:0] channels;
  logic [12:0] padded_height;
  logic [12:0] out_rows;
  logic [12:0] out_cols;
  logic [4:0]  filter_rows;
  logic [4:0]  filter_cols;
  logic [4:0]  step;

  // Pointers and position counters.
  logic [COUNT_W-1:0]     loaded_count;
  logic [COUNT_W-1:0]     read_pointer;
  logic [FILT_CNT_W-1:0]  fcol_count;
  logic [FILT_CNT_W-1:0]  frow_count;
  logic [CHAN_CNT_W-1:0]  chan_count;
  logic [BATCH_CNT_W-1:0] batch_count;
  logic [OUT_CNT_W-1:0]   ocol_count;
  logic [OUT_CNT_W-1:0]   orow_count;

  // Address arithmetic stages.
  logic [ROW_W-1:0] row_q;
  logic [ROW_W-1:0] col_q;
  logic [POS_W-1:0] pos_q;
  logic [CHN_W-1:0] chn_q;
  logic [ADR_W-1:0] addr_q;
  logic             hit;
  logic             hit_q;
  word_t            value_q;

  // Image store and its ports.
  word_t              image_store [IMAGE_DEPTH];
  word_t              rd_q;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  word_t              mem_wdata;
  logic               store_full;

  // Output register.
  word_t pixel_q;
  logic  last_q;
  logic  fin;

  // Counter wrap flags and carries.
  logic w_fcol, w_frow, w_chan, w_batch, w_ocol, w_orow;
  logic k_frow, k_chan, k_batch, k_ocol, k_orow;

  // A counter wraps at its limit less one, or when it would overflow.
  function automatic logic wraps(logic [WRAP_W-1:0] cnt, logic [WRAP_W-1:0] lim,
                                 logic full);
    wraps = (cnt + WRAP_W'(1) >= lim) || full;
  endfunction

  // Configuration writes, masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_size    <= 9'd1;
      channels      <= 11'd1;
      padded_height <= 13'd1;
      out_rows      <= 13'd1;
      out_cols      <= 13'd1;
      filter_rows   <= 5'd1;
      filter_cols   <= 5'd1;
      step          <= 5'd1;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BATCH_SIZE:    batch_size    <= cfg_data[8:0];
        REG_CHANNELS:      channels      <= cfg_data[10:0];
        REG_PADDED_HEIGHT: padded_height <= cfg_data[12:0];
        REG_OUT_ROWS:      out_rows      <= cfg_data[12:0];
        REG_OUT_COLS:      out_cols      <= cfg_data[12:0];
        REG_FILTER_ROWS:   filter_rows   <= cfg_data[4:0];
        REG_FILTER_COLS:   filter_cols   <= cfg_data[4:0];
        REG_STEP:          step          <= cfg_data[4:0];
      endcase
    end
  end

  // Carry chain of the position counters, filter column fastest.
  assign w_fcol  = wraps(WRAP_W'(fcol_count), WRAP_W'(filter_cols), &fcol_count);
  assign w_frow  = wraps(WRAP_W'(frow_count), WRAP_W'(filter_rows), &frow_count);
  assign w_chan  = wraps(WRAP_W'(chan_count), WRAP_W'(channels), &chan_count);
  assign w_batch = wraps(WRAP_W'(batch_count), WRAP_W'(batch_size), &batch_count);
  assign w_ocol  = wraps(WRAP_W'(ocol_count), WRAP_W'(out_cols), &ocol_count);
  assign w_orow  = wraps(WRAP_W'(orow_count), WRAP_W'(out_rows), &orow_count);
  assign k_frow  = w_fcol;
  assign k_chan  = k_frow && w_frow;
  assign k_batch = k_chan && w_chan;
  assign k_ocol  = k_batch && w_batch;
  assign k_orow  = k_ocol && w_ocol;

  // The final word of a readout returns all pointers and counters to the start.
  assign fin = (read_pointer + COUNT_W'(1) == loaded_count);
  assign store_full = (loaded_count == COUNT_W'(IMAGE_DEPTH));

  // Pointers and counters.
  always_ff @(posedge clk) begin
    if (rst || (cmd.out_load && fin)) begin
      loaded_count <= '0;
      read_pointer <= '0;
      fcol_count   <= '0;
      frow_count   <= '0;
      chan_count   <= '0;
      batch_count  <= '0;
      ocol_count   <= '0;
      orow_count   <= '0;
    end else begin
      if (cmd.load && !store_full) begin
        loaded_count <= loaded_count + COUNT_W'(1);
      end
      if (cmd.out_load) begin
        read_pointer <= read_pointer + COUNT_W'(1);
      end
      if (cmd.acc_read) begin
        fcol_count <= w_fcol ? '0 : fcol_count + FILT_CNT_W'(1);
        if (k_frow) begin
          frow_count <= w_frow ? '0 : frow_count + FILT_CNT_W'(1);
        end
        if (k_chan) begin
          chan_count <= w_chan ? '0 : chan_count + CHAN_CNT_W'(1);
        end
        if (k_batch) begin
          batch_count <= w_batch ? '0 : batch_count + BATCH_CNT_W'(1);
        end
        if (k_ocol) begin
          ocol_count <= w_ocol ? '0 : ocol_count + OUT_CNT_W'(1);
        end
        if (k_orow) begin
          orow_count <= w_orow ? '0 : orow_count + OUT_CNT_W'(1);
        end
      end
    end
  end

  // Address arithmetic stages, registered in between; the row stage multiplies twice.
  assign hit = (addr_q < ADR_W'(loaded_count));

  always_ff @(posedge clk) begin
    if (cmd.take_value) begin
      value_q <= word_t'(value);
    end
    if (cmd.calc_row) begin
      row_q <= ROW_W'(step) * ROW_W'(orow_count) + ROW_W'(frow_count);
      col_q <= ROW_W'(step) * ROW_W'(ocol_count) + ROW_W'(fcol_count);
    end
    if (cmd.calc_pos) begin
      pos_q <= POS_W'(padded_height) * POS_W'(col_q) + POS_W'(row_q);
    end
    if (cmd.calc_chn) begin
      chn_q <= CHN_W'(channels) * CHN_W'(pos_q) + CHN_W'(chan_count);
    end
    if (cmd.calc_adr) begin
      addr_q <= ADR_W'(batch_size) * ADR_W'(chn_q) + ADR_W'(batch_count);
    end
    if (cmd.acc_read) begin
      hit_q <= hit;
    end
  end

  // Store port selection.
  assign mem_re    = cmd.rd_issue || (cmd.acc_read && hit);
  assign mem_raddr = cmd.rd_issue ? read_pointer[ADDR_W-1:0] : addr_q[ADDR_W-1:0];
  assign mem_we    = (cmd.load && !store_full) || (cmd.acc_write && hit_q);
  assign mem_waddr = cmd.load ? loaded_count[ADDR_W-1:0] : addr_q[ADDR_W-1:0];
  assign mem_wdata = cmd.load ? word_t'(value) : word_t'(rd_q + value_q);

  // Image store, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      image_store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= image_store[mem_raddr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pixel_q <= rd_q;
      last_q  <= fin;
    end
  end

  assign pixel = pixel_q;
  assign last  = last_q;

  assign status.read_avail = (read_pointer < loaded_count);
  assign status.out_free   = !out_valid || out_ready;

endmodule

/* rtl/csa_checker.sv */
`timescale 1ns / 1ps

module csa_checker import csa_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic [1:0]             kind,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic signed [WORD_W-1:0] pixel,
  input logic                   last
);

  // A word waiting at the output holds until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(last))
    else $error("output word changed while stalled");

  // A fresh output word follows a readout that was accepted, fetched and loaded into the output register.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && kind == KIND_READ, 2))
    else $error("output word without a matching readout");

  // An accumulate occupies the block after it is accepted.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_ACCUM |=> !in_ready)
    else $error("new word taken during an accumulate");

  // A load completes in its own cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_LOAD |=> in_ready)
    else $error("load stalled the input");

endmodule

bind col2im_scatter_accumulate csa_checker u_checker (.*);
